// ===== sv/ptts_pkg.sv =====
`default_nettype none

package ptts_pkg;

    // Default table geometry.
    localparam int DEF_TASK_SLOTS = 32;
    localparam int DEF_PRIO_BITS  = 8;

    // Depth of the queues on either side of the executor.
    localparam int QUEUE_DEPTH = 2;

    // Command opcodes.
    localparam logic [1:0] OP_RESET  = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_GET    = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    // Task states with a scheduling meaning.
    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;

    // A classified command on its way to the executor.
    typedef struct packed {
        logic [1:0] op;
        logic [4:0] slot;
        logic [7:0] prio;
        logic [1:0] new_state;
        logic       bad;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot_out;
        logic [1:0] state_out;
        logic       running_valid;
        logic [4:0] running_slot;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/ptts_fifo.sv =====
`default_nettype none

module ptts_fifo
    import ptts_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] din,
    output logic                  empty,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ptts_front.sv =====
`default_nettype none

module ptts_front
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS
)
(
    input  wire logic [1:0] opcode,
    input  wire logic [4:0] slot,
    input  wire logic [7:0] prio,
    input  wire logic [1:0] new_state,
    output cmd_t            cmd
);

    logic addressed;
    logic out_of_range;
    logic asks_running;

    // Requests that can be refused without looking at the table.
    assign addressed    = (opcode == OP_SET) || (opcode == OP_GET);
    assign out_of_range = (32'(slot) >= 32'(TASK_SLOTS));
    assign asks_running = (opcode == OP_SET) && (new_state == TS_RUNNING);

    always_comb
    begin
        cmd.op        = opcode;
        cmd.slot      = slot;
        cmd.prio      = prio;
        cmd.new_state = new_state;
        cmd.bad       = (addressed && out_of_range) || asks_running;
    end

endmodule

`default_nettype wire

// ===== sv/ptts_exec.sv =====
`default_nettype none

module ptts_exec
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS,
    parameter int PRIO_BITS  = DEF_PRIO_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    output res_t      res,
    output logic      res_push,
    input  wire logic res_full
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_RDST  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FINAL = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Task state and priority tables.
    logic [1:0]           st_mem [TASK_SLOTS];
    logic [PRIO_BITS-1:0] pr_mem [TASK_SLOTS];
    logic [1:0]           st_q;
    logic [PRIO_BITS-1:0] pr_q;
    logic                 st_we;
    logic [SLOT_W-1:0]    st_wa;
    logic [1:0]           st_wd;
    logic                 pr_we;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;

    logic [2:0]            state_reg,     state_next;
    logic [1:0]            op_reg,        op_next;
    logic [1:0]            ns_reg,        ns_next;
    logic [PRIO_BITS-1:0]  prio_reg,      prio_next;
    logic [SLOT_W-1:0]     target_reg,    target_next;
    logic [SLOT_W-1:0]     idx_reg,       idx_next;
    logic                  p_vld_reg,     p_vld_next;
    logic [SLOT_W-1:0]     p_idx_reg,     p_idx_next;
    logic                  found_reg,     found_next;
    logic [SLOT_W-1:0]     best_reg,      best_next;
    logic [PRIO_BITS-1:0]  best_prio_reg, best_prio_next;
    logic [TASK_SLOTS-1:0] used_reg,      used_next;
    logic                  run_valid_reg, run_valid_next;
    logic [SLOT_W-1:0]     run_slot_reg,  run_slot_next;
    logic [1:0]            status_reg,    status_next;
    logic [4:0]            sout_reg,      sout_next;
    logic [1:0]            stout_reg,     stout_next;

    logic [31:0]       slot_ext;
    logic [SLOT_W-1:0] cmd_idx;
    logic [31:0]       prio_ext;
    logic [31:0]       idx_ext;
    logic [31:0]       run_ext;
    logic              p_used;

    assign slot_ext = 32'(cmd.slot);
    assign cmd_idx  = slot_ext[SLOT_W-1:0];
    assign prio_ext = 32'(cmd.prio);
    assign idx_ext  = 32'(idx_reg);
    assign run_ext  = 32'(run_slot_reg);
    assign p_used   = used_reg[p_idx_reg];

    assign res.status        = status_reg;
    assign res.slot_out      = sout_reg;
    assign res.state_out     = stout_reg;
    assign res.running_valid = run_valid_reg;
    assign res.running_slot  = run_ext[4:0];

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ns_next        = ns_reg;
        prio_next      = prio_reg;
        target_next    = target_reg;
        idx_next       = idx_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = p_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_prio_next = best_prio_reg;
        used_next      = used_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        status_next    = status_reg;
        sout_next      = sout_reg;
        stout_next     = stout_reg;
        st_we          = 1'b0;
        st_wa          = idx_reg;
        st_wd          = TS_READY;
        pr_we          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = cmd_idx;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                rd_en = 1'b1;
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    op_next     = cmd.op;
                    ns_next     = cmd.new_state;
                    prio_next   = prio_ext[PRIO_BITS-1:0];
                    target_next = cmd_idx;
                    sout_next   = cmd.slot;
                    stout_next  = '0;
                    status_next = STAT_OK;
                    if (cmd.bad)
                    begin
                        status_next = STAT_BAD;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        case (cmd.op)
                            OP_RESET:
                            begin
                                used_next      = '0;
                                run_valid_next = 1'b0;
                                run_slot_next  = '0;
                                sout_next      = '0;
                                state_next     = S_DONE;
                            end
                            OP_CREATE:
                            begin
                                idx_next   = '0;
                                sout_next  = '0;
                                state_next = S_FIND;
                            end
                            default:
                            begin
                                if (!used_reg[cmd_idx])
                                begin
                                    status_next = STAT_BAD;
                                    state_next  = S_DONE;
                                end
                                else
                                begin
                                    state_next = S_RDST;
                                end
                            end
                        endcase
                    end
                end
            end
            S_FIND:
            begin
                if (!used_reg[idx_reg])
                begin
                    used_next[idx_reg] = 1'b1;
                    st_we       = 1'b1;
                    st_wa       = idx_reg;
                    st_wd       = TS_READY;
                    pr_we       = 1'b1;
                    target_next = idx_reg;
                    sout_next   = idx_ext[4:0];
                    stout_next  = TS_READY;
                    found_next  = 1'b0;
                    idx_next    = '0;
                    state_next  = S_SCAN;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    status_next = STAT_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RDST:
            begin
                if (op_reg == OP_GET)
                begin
                    stout_next = st_q;
                    state_next = S_DONE;
                end
                else if (st_q == ns_reg)
                begin
                    stout_next = ns_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    st_we      = 1'b1;
                    st_wa      = target_reg;
                    st_wd      = ns_reg;
                    stout_next = ns_reg;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                p_vld_next = 1'b1;
                p_idx_next = idx_reg;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (found_reg)
                begin
                    st_we = 1'b1;
                    st_wa = best_reg;
                    st_wd = TS_RUNNING;
                    if (best_reg == target_reg)
                    begin
                        stout_next = TS_RUNNING;
                    end
                end
                run_valid_next = found_reg;
                run_slot_next  = found_reg ? best_reg : '0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Scan evaluation, one slot behind the read: demote a running task
        // and track the best ready candidate. Only active in SCAN and DRAIN.
        if (p_vld_reg && p_used)
        begin
            if (st_q == TS_RUNNING)
            begin
                st_we = 1'b1;
                st_wa = p_idx_reg;
                st_wd = TS_READY;
            end
            if ((st_q == TS_READY) || (st_q == TS_RUNNING))
            begin
                if (!found_reg || (pr_q > best_prio_reg))
                begin
                    found_next     = 1'b1;
                    best_next      = p_idx_reg;
                    best_prio_next = pr_q;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        if (pr_we)
        begin
            pr_mem[idx_reg] <= prio_reg;
        end
        if (rd_en)
        begin
            st_q <= st_mem[rd_addr];
            pr_q <= pr_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RESET;
            ns_reg        <= TS_READY;
            prio_reg      <= '0;
            target_reg    <= '0;
            idx_reg       <= '0;
            p_vld_reg     <= 1'b0;
            p_idx_reg     <= '0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_prio_reg <= '0;
            used_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            status_reg    <= STAT_OK;
            sout_reg      <= '0;
            stout_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ns_reg        <= ns_next;
            prio_reg      <= prio_next;
            target_reg    <= target_next;
            idx_reg       <= idx_next;
            p_vld_reg     <= p_vld_next;
            p_idx_reg     <= p_idx_next;
            found_reg     <= found_next;
            best_reg      <= best_next;
            best_prio_reg <= best_prio_next;
            used_reg      <= used_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            status_reg    <= status_next;
            sout_reg      <= sout_next;
            stout_reg     <= stout_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/priority_task_table_scheduler.sv =====
// Fixed-priority task table. Each command transaction (reset table, create
// task, set task state, get task state) yields exactly one result transaction,
// in order. Commands enter through a two-entry command queue after a front
// stage has refused the requests that need no table lookup; a single executor
// then works through them one at a time, and results leave through a two-entry
// result queue, so either side may stall without holding up the other. A
// create probes the slots from the lowest upward for the first free one, and
// both a successful create and a set-state that changes a state run a
// scheduling pass, which reads the state and priority tables one slot per
// cycle through their single read port. Priorities keep their low PRIO_BITS
// bits; slot numbers on the result ports carry the low five bits of the
// index. The in-use marks clear at reset; the state and priority tables
// need no clearing, since an entry is only read while its slot is in use.
`default_nettype none

module priority_task_table_scheduler
    import ptts_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS,
    parameter int PRIO_BITS  = DEF_PRIO_BITS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] opcode,
    input  wire logic [4:0] slot,
    input  wire logic [7:0] prio,
    input  wire logic [1:0] new_state,
    output logic            empty,
    input  wire logic       pop,
    output logic      [1:0] status,
    output logic      [4:0] slot_out,
    output logic      [1:0] state_out,
    output logic            running_valid,
    output logic      [4:0] running_slot
);

    cmd_t cmd_in;
    cmd_t cmd_q;
    logic cmd_empty;
    logic cmd_pop;
    res_t res_d;
    res_t res_q;
    logic res_push;
    logic res_full;

    // Front: classify the incoming transaction.
    ptts_front #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_front (
        .opcode    (opcode),
        .slot      (slot),
        .prio      (prio),
        .new_state (new_state),
        .cmd       (cmd_in)
    );

    // Command queue between the front and the executor.
    ptts_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (cmd_in),
        .empty (cmd_empty),
        .pop   (cmd_pop),
        .dout  (cmd_q)
    );

    // Back: owns the task table and runs the scheduling passes.
    ptts_exec #(
        .TASK_SLOTS (TASK_SLOTS),
        .PRIO_BITS  (PRIO_BITS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_q),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res_d),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue toward the consumer.
    ptts_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_d),
        .empty (empty),
        .pop   (pop),
        .dout  (res_q)
    );

    assign status        = res_q.status;
    assign slot_out      = res_q.slot_out;
    assign state_out     = res_q.state_out;
    assign running_valid = res_q.running_valid;
    assign running_slot  = res_q.running_slot;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ptts_pkg::*;

    // The block is built with its default table geometry, so the scoreboard
    // keeps a table of the same size.
    localparam int NUM_SLOTS   = DEF_TASK_SLOTS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_CMDS = 500;

    // One command transaction as the stimulus generator builds it. The
    // drain_first mark makes the driver hold the command back until every
    // earlier result has been checked.
    typedef struct {
        logic [1:0] op;
        logic [4:0] slot;
        logic [7:0] prio;
        logic [1:0] new_state;
        bit         drain_first;
    } sched_cmd_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [1:0] opcode = OP_RESET;
    logic [4:0] slot = '0;
    logic [7:0] prio = '0;
    logic [1:0] new_state = TS_READY;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] status;
    logic [4:0] slot_out;
    logic [1:0] state_out;
    logic       running_valid;
    logic [4:0] running_slot;

    priority_task_table_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .slot          (slot),
        .prio          (prio),
        .new_state     (new_state),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .slot_out      (slot_out),
        .state_out     (state_out),
        .running_valid (running_valid),
        .running_slot  (running_slot)
    );

    // Commands waiting to be driven, and the results the scoreboard predicts
    // for commands the block has already accepted, oldest first.
    sched_cmd_t pending_cmds[$];
    res_t       expected_results[$];

    // The two counters are only ever updated with nonblocking assignments, so
    // the driver and the monitor both see values from before the current edge
    // and their comparison never depends on which always block runs first.
    int n_accepted = 0;
    int n_checked  = 0;
    int errors     = 0;
    int cycle_count = 0;

    // Scoreboard copy of the task table.
    bit         tbl_used[NUM_SLOTS];
    logic [1:0] tbl_state[NUM_SLOTS];
    logic [7:0] tbl_prio[NUM_SLOTS];
    bit         run_on;
    logic [4:0] run_idx;

    // Shadow of the in-use marks seen by the generator. Which slots are in use
    // depends only on the order of creates and table resets, so the generator
    // can aim set-state and get-state at live tasks without the full model.
    bit gen_used[NUM_SLOTS];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A scheduling pass: the running task drops back to ready, then the ready
    // task with the highest priority wins, with the lowest slot breaking ties.
    function void reschedule_tasks();
        bit found;
        int best;
        found = 1'b0;
        best = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (tbl_used[i] && tbl_state[i] == TS_RUNNING)
                tbl_state[i] = TS_READY;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (tbl_used[i] && tbl_state[i] == TS_READY && (!found || tbl_prio[i] > tbl_prio[best]))
            begin
                best = i;
                found = 1'b1;
            end
        end
        if (found)
            tbl_state[best] = TS_RUNNING;
        run_on = found;
        run_idx = found ? best[4:0] : 5'd0;
    endfunction

    // Applies one accepted command to the scoreboard table and returns the
    // result transaction the block must produce for it.
    function res_t predict_result(sched_cmd_t c);
        res_t r;
        bit   got;
        r = '0;
        got = 1'b0;
        case (c.op)
            OP_RESET:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    tbl_used[i] = 1'b0;
                run_on = 1'b0;
                run_idx = '0;
            end
            OP_CREATE:
            begin
                for (int i = 0; i < NUM_SLOTS && !got; i++)
                begin
                    if (!tbl_used[i])
                    begin
                        got = 1'b1;
                        tbl_used[i] = 1'b1;
                        tbl_prio[i] = c.prio;
                        tbl_state[i] = TS_READY;
                        r.slot_out = i[4:0];
                    end
                end
                if (got)
                begin
                    reschedule_tasks();
                    r.state_out = tbl_state[r.slot_out];
                end
                else
                    r.status = STAT_FULL;
            end
            default:
            begin
                r.slot_out = c.slot;
                if (!tbl_used[c.slot])
                    r.status = STAT_BAD;
                else if (c.op == OP_SET)
                begin
                    if (c.new_state == TS_RUNNING)
                        r.status = STAT_BAD;
                    else
                    begin
                        // Writing the state a task already has is accepted but
                        // does not trigger a scheduling pass.
                        if (tbl_state[c.slot] != c.new_state)
                        begin
                            tbl_state[c.slot] = c.new_state;
                            reschedule_tasks();
                        end
                        r.state_out = tbl_state[c.slot];
                    end
                end
                else
                    r.state_out = tbl_state[c.slot];
            end
        endcase
        r.running_valid = run_on;
        r.running_slot = run_idx;
        return r;
    endfunction

    // Queues one command and keeps the generator's view of the in-use marks.
    task add_cmd(logic [1:0] op, logic [4:0] s, logic [7:0] p, logic [1:0] ns, bit drain);
        sched_cmd_t c;
        bit placed;
        c.op = op;
        c.slot = s;
        c.prio = p;
        c.new_state = ns;
        c.drain_first = drain;
        placed = 1'b0;
        pending_cmds.push_back(c);
        if (op == OP_RESET)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                gen_used[i] = 1'b0;
        end
        else if (op == OP_CREATE)
        begin
            for (int i = 0; i < NUM_SLOTS && !placed; i++)
            begin
                if (!gen_used[i])
                begin
                    gen_used[i] = 1'b1;
                    placed = 1'b1;
                end
            end
        end
    endtask

    // Mostly a slot that holds a task, sometimes any slot at all so that free
    // slots and every bit of the slot field are exercised.
    function automatic logic [4:0] pick_slot();
        int n = 0;
        int k;
        for (int i = 0; i < NUM_SLOTS; i++)
            n += gen_used[i];
        if (n == 0 || $urandom_range(0, 99) < 15)
            return 5'($urandom_range(0, NUM_SLOTS - 1));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (gen_used[i])
            begin
                if (k == 0)
                    return i[4:0];
                k--;
            end
        end
        return '0;
    endfunction

    function automatic logic [1:0] pick_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return TS_READY;
        if (r < 50)
            return TS_RUNNING;
        return (r < 75) ? 2'd2 : 2'd3;
    endfunction

    // Stimulus, then the end of the run.
    initial
    begin
        int n_random;
        int ep_len;
        int create_pct;
        int r;

        // Directed opening: requests on free slots, the lowest and highest
        // priorities, a priority tie, the running state being requested, a
        // state that does not change, demotion of the running task, and a
        // table reset followed by a lookup of a slot it freed.
        add_cmd(OP_GET,    5'd0,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_SET,    5'd31, 8'h00, TS_READY,   1'b0);
        add_cmd(OP_CREATE, 5'd0,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_CREATE, 5'd31, 8'hff, 2'd3,       1'b0);
        add_cmd(OP_CREATE, 5'd0,  8'hff, TS_READY,   1'b0);
        add_cmd(OP_GET,    5'd1,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, TS_RUNNING, 1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, 2'd2,       1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, 2'd2,       1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, 2'd3,       1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_SET,    5'd2,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_SET,    5'd1,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_CREATE, 5'd10, 8'haa, TS_READY,   1'b0);
        add_cmd(OP_CREATE, 5'd21, 8'h55, TS_READY,   1'b0);
        add_cmd(OP_GET,    5'd31, 8'h00, TS_READY,   1'b0);
        add_cmd(OP_SET,    5'd0,  8'h00, 2'd3,       1'b0);
        add_cmd(OP_GET,    5'd0,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_RESET,  5'd31, 8'hff, 2'd3,       1'b0);
        add_cmd(OP_GET,    5'd1,  8'h00, TS_READY,   1'b0);
        add_cmd(OP_CREATE, 5'd0,  8'h01, TS_READY,   1'b0);

        // Random part, in episodes that each open with a table reset. Some
        // episodes lean on creates hard enough to fill the table; the rest
        // mostly move tasks between states and read them back.
        n_random = 0;
        while (n_random < RANDOM_CMDS)
        begin
            ep_len = $urandom_range(30, 90);
            create_pct = ($urandom_range(0, 1) == 0) ? 25 : 55;
            add_cmd(OP_RESET, 5'($urandom), 8'($urandom), 2'($urandom), n_random == 0);
            n_random++;
            for (int j = 0; j < ep_len; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 1)
                    add_cmd(OP_RESET, 5'($urandom), 8'($urandom), 2'($urandom), 1'b0);
                else if (r < 1 + create_pct)
                    add_cmd(OP_CREATE, 5'($urandom), 8'($urandom), 2'($urandom), 1'b0);
                else if ($urandom_range(0, 9) < 6)
                    add_cmd(OP_SET, pick_slot(), 8'($urandom), pick_state(), 1'b0);
                else
                    add_cmd(OP_GET, pick_slot(), 8'($urandom), 2'($urandom),
                            $urandom_range(0, 99) == 0);
                n_random++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Everything has been driven and checked once no command is pending,
        // none is on the ports, and every accepted one has had its result.
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || push || n_checked != n_accepted);

        // A further stretch to catch any stray result transaction.
        repeat (150) @(negedge clk);
        if (errors == 0)
            $display("[priority_task_table_scheduler] OK");
        else
            $display("[priority_task_table_scheduler] ERROR");
        $finish;
    end

    // Command driver. It sends in bursts of random length separated by random
    // gaps, and a zero gap now and then gives back-to-back stretches. A command
    // stays on the ports until the block takes it.
    sched_cmd_t cur_cmd;
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge clk)
    begin
        bit accepted;
        int outstanding;
        accepted = push && !full;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (accepted)
            begin
                expected_results.push_back(predict_result(cur_cmd));
                n_accepted <= n_accepted + 1;
            end
            if (!push || accepted)
            begin
                outstanding = n_accepted + (accepted ? 1 : 0) - n_checked;
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_cmds.size() != 0 && !(pending_cmds[0].drain_first && outstanding != 0))
                begin
                    cur_cmd = pending_cmds.pop_front();
                    opcode <= cur_cmd.op;
                    slot <= cur_cmd.slot;
                    prio <= cur_cmd.prio;
                    new_state <= cur_cmd.new_state;
                    push <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 3);
                            2: gap_left = $urandom_range(4, 20);
                            default: gap_left = $urandom_range(30, 80);
                        endcase
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    task compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result monitor. The receiver switches at random between three moods:
    // never stalling, stalling in frequent short spells, or taking rare long
    // breaks.
    int rx_mode = 0;
    int mode_left = 200;
    int stall_left = 0;

    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (n_checked >= n_accepted)
                begin
                    $display("%0t: result transaction with none expected, got status %0d slot %0d",
                             $time, status, slot_out);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", 8'(want.status), 8'(status));
                    compare_field("slot_out", 8'(want.slot_out), 8'(slot_out));
                    compare_field("state_out", 8'(want.state_out), 8'(state_out));
                    compare_field("running_valid", 8'(want.running_valid),
                                  8'(running_valid));
                    compare_field("running_slot", 8'(want.running_slot),
                                  8'(running_slot));
                    n_checked <= n_checked + 1;
                end
            end

            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(100, 400);
            end
            else
                mode_left--;

            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (rx_mode == 1 && $urandom_range(0, 1) == 1)
                    stall_left = $urandom_range(1, 3);
                else if (rx_mode == 2 && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(5, 30);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("[priority_task_table_scheduler] ERROR");
            $finish;
        end
    end

endmodule
